FILE: src/euler_scale_transform_matrix_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the transform setup engine
// Shared property forms, clocked on the rising edge, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef EULER_SCALE_TRANSFORM_MATRIX_ASSERT_SVH
`define EULER_SCALE_TRANSFORM_MATRIX_ASSERT_SVH

// a holds, so b holds in the same cycle
`define ESM_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// a holds, so b holds in the next cycle
`define ESM_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

FILE: src/esm_pkg.sv
// ---------------------------------------------------------------------------
// esm_pkg
// Types, constants and the arctangent table of the transform setup engine.
// ---------------------------------------------------------------------------
package esm_pkg;

  localparam int CORDIC_ITERS = 30;
  localparam int PIPE_STAGES  = 33;  // one quotient bit per stage
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [2:0] K_OFFSET = 3'd3;
  localparam logic [2:0] K_NORMAL = 3'd4;
  localparam logic [2:0] K_LAST   = 3'd6;

  localparam logic signed [31:0] Q16_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

  // rotator state of one angle
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic               flip;
  } trig_t;

  // restoring divider state of one reciprocal
  typedef struct packed {
    logic [23:0] mag;
    logic        neg;
    logic        zero;
    logic [24:0] rem;
    logic [32:0] quo;
  } div_t;

  // one word in flight through the iteration pipeline
  typedef struct packed {
    trig_t [2:0]       tr;
    div_t  [2:0]       dv;
    logic  [2:0][23:0] scale;
    logic  [2:0][31:0] offset;
  } iter_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: src/esm_iter.sv
// ---------------------------------------------------------------------------
// esm_iter
// One pipeline stage: a rotation step for three angles (in stages below
// CORDIC_ITERS only) and one quotient bit for three reciprocals.
// ---------------------------------------------------------------------------
module esm_iter #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  esm_pkg::iter_t d,
  output logic          out_vld,
  output esm_pkg::iter_t q
);

  localparam int BIT = 32 - STAGE;

  esm_pkg::iter_t    nx;
  logic [2:0][32:0]  nvec;
  logic [2:0][24:0]  r2;
  logic [31:0]       atan;

  assign atan = esm_pkg::atan_turn(5'(STAGE));

  // rotation step and divider step
  always_comb begin
    nx = d;
    for (int a = 0; a < 3; a++) begin
      if (STAGE < esm_pkg::CORDIC_ITERS) begin
        if (!d.tr[a].z[32]) begin
          nx.tr[a].x = d.tr[a].x - ($signed(d.tr[a].y) >>> STAGE);
          nx.tr[a].y = d.tr[a].y + ($signed(d.tr[a].x) >>> STAGE);
          nx.tr[a].z = d.tr[a].z - $signed({1'b0, atan});
        end else begin
          nx.tr[a].x = d.tr[a].x + ($signed(d.tr[a].y) >>> STAGE);
          nx.tr[a].y = d.tr[a].y - ($signed(d.tr[a].x) >>> STAGE);
          nx.tr[a].z = d.tr[a].z + $signed({1'b0, atan});
        end
      end
      // dividend is 2^32 + mag/2
      nvec[a] = {1'b1, 9'b0, d.dv[a].mag[23:1]};
      r2[a]   = {d.dv[a].rem[23:0], nvec[a][BIT]};
      if (r2[a] >= {1'b0, d.dv[a].mag}) begin
        nx.dv[a].rem      = r2[a] - {1'b0, d.dv[a].mag};
        nx.dv[a].quo[BIT] = 1'b1;
      end else begin
        nx.dv[a].rem = r2[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nx;
    end
  end

endmodule

FILE: src/esm_rotation.sv
// ---------------------------------------------------------------------------
// esm_rotation
// Three stages: sine/cosine and reciprocal finish, pair products, rotation
// matrix entries.
// ---------------------------------------------------------------------------
module esm_rotation #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  esm_pkg::iter_t                    d,
  output logic                              out_vld,
  output logic signed [TRIG_FRAC_BITS+2:0]  r [9],
  output logic signed [31:0]                inv [3],
  output logic [2:0]                        isat,
  output logic signed [23:0]                scale [3],
  output logic signed [31:0]                offset [3]
);

  localparam int F  = TRIG_FRAC_BITS;
  localparam int RW = F + 3;
  localparam logic signed [32:0] HALF_T = 33'sd1 <<< (29 - F);
  localparam logic signed [32:0] LIM    = 33'sd1 <<< F;
  localparam logic signed [2*RW-1:0] HALF_P = (2*RW)'(1) <<< (F - 1);

  function automatic logic signed [RW-1:0] mulf(input logic signed [RW-1:0] a,
                                                input logic signed [RW-1:0] b);
    logic signed [2*RW-1:0] p;
    p = a * b;
    p = p + HALF_P;
    return RW'(p >>> F);
  endfunction

  // stage A
  logic                     va;
  logic signed [RW-1:0]     ca [3];
  logic signed [RW-1:0]     sa [3];
  logic signed [RW-1:0]     ca_next [3];
  logic signed [RW-1:0]     sa_next [3];
  logic signed [31:0]       inva [3];
  logic signed [31:0]       inva_next [3];
  logic [2:0]               isata;
  logic [2:0]               isata_next;
  logic signed [23:0]       sca [3];
  logic signed [31:0]       ofa [3];
  logic signed [32:0]       xr [3];
  logic signed [32:0]       yr [3];
  logic signed [34:0]       qv [3];

  // round, clamp and unfold sine/cosine; sign and clamp reciprocals
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      xr[a] = ($signed(d.tr[a].x) + HALF_T) >>> (30 - F);
      yr[a] = ($signed(d.tr[a].y) + HALF_T) >>> (30 - F);
      if (xr[a] > LIM)  xr[a] = LIM;
      if (xr[a] < -LIM) xr[a] = -LIM;
      if (yr[a] > LIM)  yr[a] = LIM;
      if (yr[a] < -LIM) yr[a] = -LIM;
      if (d.tr[a].flip) begin
        xr[a] = -xr[a];
        yr[a] = -yr[a];
      end
      ca_next[a] = RW'(xr[a]);
      sa_next[a] = RW'(yr[a]);

      qv[a] = $signed({2'b00, d.dv[a].quo});
      if (d.dv[a].neg) qv[a] = -qv[a];
      isata_next[a] = 1'b0;
      if (d.dv[a].zero) begin
        inva_next[a]  = esm_pkg::I32_MAX;
        isata_next[a] = 1'b1;
      end else if (qv[a] > 35'(esm_pkg::I32_MAX)) begin
        inva_next[a]  = esm_pkg::I32_MAX;
        isata_next[a] = 1'b1;
      end else if (qv[a] < 35'(esm_pkg::I32_MIN)) begin
        inva_next[a]  = esm_pkg::I32_MIN;
        isata_next[a] = 1'b1;
      end else begin
        inva_next[a] = 32'(qv[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        ca[a]   <= ca_next[a];
        sa[a]   <= sa_next[a];
        inva[a] <= inva_next[a];
        sca[a]  <= $signed(d.scale[a]);
        ofa[a]  <= $signed(d.offset[a]);
      end
      isata <= isata_next;
    end
  end

  // stage B: products of pairs (index 0 from y, 1 from x, 2 from z)
  logic                 vb;
  logic signed [RW-1:0] s1s2, c1s2, c1c3, c2s3, c3s1, c1s3, c2c3, s1s3, c2s1, c1c2;
  logic signed [RW-1:0] s3b, c3b, ns2;
  logic signed [31:0]   invb [3];
  logic [2:0]           isatb;
  logic signed [23:0]   scb [3];
  logic signed [31:0]   ofb [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s1s2 <= mulf(sa[0], sa[1]);
      c1s2 <= mulf(ca[0], sa[1]);
      c1c3 <= mulf(ca[0], ca[2]);
      c2s3 <= mulf(ca[1], sa[2]);
      c3s1 <= mulf(ca[2], sa[0]);
      c1s3 <= mulf(ca[0], sa[2]);
      c2c3 <= mulf(ca[1], ca[2]);
      s1s3 <= mulf(sa[0], sa[2]);
      c2s1 <= mulf(ca[1], sa[0]);
      c1c2 <= mulf(ca[0], ca[1]);
      s3b  <= sa[2];
      c3b  <= ca[2];
      ns2  <= -sa[1];
      invb  <= inva;
      isatb <= isata;
      scb   <= sca;
      ofb   <= ofa;
    end
  end

  // stage C: matrix entries, column major
  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= c1c3 + mulf(s1s2, s3b);
      r[1] <= c2s3;
      r[2] <= mulf(c1s2, s3b) - c3s1;
      r[3] <= mulf(c3b, s1s2) - c1s3;
      r[4] <= c2c3;
      r[5] <= mulf(c3b, c1s2) + s1s3;
      r[6] <= c2s1;
      r[7] <= ns2;
      r[8] <= c1c2;
      inv    <= invb;
      isat   <= isatb;
      scale  <= scb;
      offset <= ofb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va      <= 1'b0;
      vb      <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      va      <= in_vld;
      vb      <= va;
      out_vld <= vb;
    end
  end

endmodule

FILE: src/esm_column.sv
// ---------------------------------------------------------------------------
// esm_column
// Holds one finished word and issues its seven column words, one a cycle while
// the output is not stalled, through an output register.
// ---------------------------------------------------------------------------
`include "euler_scale_transform_matrix_assert.svh"

module esm_column #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_vld,
  input  logic signed [TRIG_FRAC_BITS+2:0]  r [9],
  input  logic signed [31:0]                inv [3],
  input  logic [2:0]                        isat,
  input  logic signed [23:0]                scale [3],
  input  logic signed [31:0]                offset [3],
  output logic                              take,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              which_matrix,
  output logic [1:0]                        column,
  output logic signed [31:0]                elem0,
  output logic signed [31:0]                elem1,
  output logic signed [31:0]                elem2,
  output logic signed [31:0]                elem3,
  output logic                              saturated,
  output logic                              last
);

  localparam int F  = TRIG_FRAC_BITS;
  localparam int RW = F + 3;
  localparam int PW = 32 + RW;
  localparam logic signed [PW-1:0] HALF  = PW'(1) <<< (F - 1);
  localparam logic signed [PW-1:0] E_MAX = PW'(esm_pkg::I32_MAX);
  localparam logic signed [PW-1:0] E_MIN = PW'(esm_pkg::I32_MIN);

  logic signed [RW-1:0] h_r [9];
  logic signed [31:0]   h_inv [3];
  logic [2:0]           h_isat;
  logic signed [23:0]   h_scale [3];
  logic signed [31:0]   h_offset [3];
  logic                 hv;
  logic [2:0]           k;
  logic                 load;

  logic [1:0]           col;
  logic [1:0]           cidx;
  logic                 normal;
  logic signed [31:0]   factor;
  logic signed [PW-1:0] prod [3];
  logic signed [31:0]   e_next [4];
  logic                 sat_next;

  assign load = hv && (!out_valid || !out_stall);
  assign take = !hv || (load && k == esm_pkg::K_LAST);

  // hold register and column count
  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      k  <= 3'd0;
    end else if (take && item_vld) begin
      hv <= 1'b1;
      k  <= 3'd0;
    end else if (load) begin
      if (k == esm_pkg::K_LAST) hv <= 1'b0;
      k <= k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item_vld) begin
      h_r      <= r;
      h_inv    <= inv;
      h_isat   <= isat;
      h_scale  <= scale;
      h_offset <= offset;
    end
  end

  // column entries
  always_comb begin
    normal   = (k >= esm_pkg::K_NORMAL);
    col      = normal ? 2'(k - esm_pkg::K_NORMAL) : k[1:0];
    cidx     = (col == 2'd3) ? 2'd0 : col;
    factor   = normal ? h_inv[cidx] : 32'(h_scale[cidx]);
    sat_next = normal ? h_isat[cidx] : 1'b0;
    for (int j = 0; j < 3; j++) begin
      prod[j] = factor * h_r[4'(cidx * 3 + j)];
      prod[j] = (prod[j] + HALF) >>> F;
      if (normal && prod[j] > E_MAX) begin
        e_next[j] = esm_pkg::I32_MAX;
        sat_next  = 1'b1;
      end else if (normal && prod[j] < E_MIN) begin
        e_next[j] = esm_pkg::I32_MIN;
        sat_next  = 1'b1;
      end else begin
        e_next[j] = 32'(prod[j]);
      end
    end
    e_next[3] = 32'sd0;
    if (k == esm_pkg::K_OFFSET) begin
      for (int j = 0; j < 3; j++) e_next[j] = h_offset[j];
      e_next[3] = esm_pkg::Q16_ONE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      which_matrix <= normal;
      column       <= col;
      elem0        <= e_next[0];
      elem1        <= e_next[1];
      elem2        <= e_next[2];
      elem3        <= e_next[3];
      saturated    <= sat_next;
      last         <= (k == esm_pkg::K_LAST);
    end
  end

  `ESM_ASSERT_IMPLIES(a_k_range, clk, rst, hv, k <= esm_pkg::K_LAST)
  `ESM_ASSERT_IMPLIES(a_last_col, clk, rst, out_valid && last, which_matrix && column == 2'd2)
  `ESM_ASSERT_IMPLIES(a_model_nosat, clk, rst, out_valid && !which_matrix, !saturated)
  `ESM_ASSERT_NEXT(a_last_next, clk, rst, load && k == esm_pkg::K_LAST, out_valid && last)

endmodule

FILE: src/euler_scale_transform_matrix.sv
// ---------------------------------------------------------------------------
// euler_scale_transform_matrix
// Y-X-Z rotation model matrix and reciprocal-scale normal matrix, seven
// column words per input word.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_stall  | angle_x..z, scale_x..z, offset_x..z
//  output  | out_valid / out_stall| which_matrix, column, elem0..3, saturated,
//          |                      | last
//
// The input rate is set by the column issue register, which sends one column
// word a cycle while the output is not stalled and takes the next word as it
// issues the last column. The path to the first column runs through 33
// rotation/quotient stages, 3 matrix stages, the hold and output registers.
// Reset clears valid bits and the column count only.
// A stall holds the pipeline in place once a finished word waits at the hold register; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module euler_scale_transform_matrix #(
  parameter int ANGLE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        angle_x,
  input  logic [15:0]        angle_y,
  input  logic [15:0]        angle_z,
  input  logic signed [23:0] scale_x,
  input  logic signed [23:0] scale_y,
  input  logic signed [23:0] scale_z,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               which_matrix,
  output logic [1:0]         column,
  output logic signed [31:0] elem0,
  output logic signed [31:0] elem1,
  output logic signed [31:0] elem2,
  output logic signed [31:0] elem3,
  output logic               saturated,
  output logic               last
);

  localparam int NS  = esm_pkg::PIPE_STAGES;
  localparam int RW  = TRIG_FRAC_BITS + 3;
  localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam int ASH = 32 - ANGLE_BITS;

  esm_pkg::iter_t pipe [NS+1];
  logic           pv [NS+1];
  logic           en;
  logic           rot_vld;
  logic           take;

  logic [15:0]        ang [3];
  logic signed [23:0] scl [3];
  logic [31:0]        aw [3];

  logic signed [RW-1:0] r [9];
  logic signed [31:0]   inv [3];
  logic [2:0]           isat;
  logic signed [23:0]   scale [3];
  logic signed [31:0]   offset [3];

  // whole pipeline moves unless a finished word waits and the hold register cannot take it
  assign en       = !rot_vld || take;
  assign in_stall = !en;
  assign pv[0]    = in_valid;

  assign ang[0] = angle_y;
  assign ang[1] = angle_x;
  assign ang[2] = angle_z;
  assign scl[0] = scale_x;
  assign scl[1] = scale_y;
  assign scl[2] = scale_z;

  // quadrant fold and divider set-up
  always_comb begin
    pipe[0] = '0;
    for (int a = 0; a < 3; a++) begin
      aw[a] = (32'(ang[a]) & AMASK) << ASH;
      pipe[0].tr[a].flip = 1'b0;
      if ((aw[a] + 32'h4000_0000) >= 32'h8000_0000) begin
        aw[a] = aw[a] - 32'h8000_0000;
        pipe[0].tr[a].flip = 1'b1;
      end
      pipe[0].tr[a].x = esm_pkg::CORDIC_GAIN;
      pipe[0].tr[a].y = 33'sd0;
      pipe[0].tr[a].z = $signed({aw[a][31], aw[a]});
      pipe[0].dv[a].neg  = scl[a][23];
      pipe[0].dv[a].zero = (scl[a] == 24'sd0);
      pipe[0].dv[a].mag  = scl[a][23] ? 24'(-scl[a]) : 24'(scl[a]);
      pipe[0].scale[a]   = scl[a];
    end
    pipe[0].offset[0] = offset_x;
    pipe[0].offset[1] = offset_y;
    pipe[0].offset[2] = offset_z;
  end

  for (genvar s = 0; s < NS; s++) begin : g_iter
    esm_iter #(.STAGE(s)) u_iter (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (pv[s]),
      .d       (pipe[s]),
      .out_vld (pv[s+1]),
      .q       (pipe[s+1])
    );
  end

  esm_rotation #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rotation (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (pv[NS]),
    .d       (pipe[NS]),
    .out_vld (rot_vld),
    .r       (r),
    .inv     (inv),
    .isat    (isat),
    .scale   (scale),
    .offset  (offset)
  );

  esm_column #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_column (
    .clk          (clk),
    .rst          (rst),
    .item_vld     (rot_vld),
    .r            (r),
    .inv          (inv),
    .isat         (isat),
    .scale        (scale),
    .offset       (offset),
    .take         (take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .which_matrix (which_matrix),
    .column       (column),
    .elem0        (elem0),
    .elem1        (elem1),
    .elem2        (elem2),
    .elem3        (elem3),
    .saturated    (saturated),
    .last         (last)
  );

endmodule
